// ===== design/tphc_pkg.sv =====
// ----------------------------------------------------------------------------
// tphc_pkg
// Shared types, constants and the ones'-complement add helper of the transport
// pseudo-header checksum unit.
// ----------------------------------------------------------------------------
package tphc_pkg;

  localparam int unsigned SumW      = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned ProtoW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [ProtoW-1:0] ProtoReset = 8'd17;

  // Segment queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_ADDR = 2'd0,
    CFG_DST_ADDR = 2'd1,
    CFG_PROTO    = 2'd2
  } cfg_reg_e;

  // One finished segment: data sum (odd byte folded in) and wrapped byte count
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [SumW-1:0] count;
  } seg_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // 16-bit ones'-complement add with end-around carry
  function automatic logic [SumW-1:0] oc_add(input logic [SumW-1:0] a,
                                             input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW-1:0] + {{(SumW-1){1'b0}}, s[SumW]};
  endfunction

endpackage

// ===== design/tphc_cfg.sv =====
// ----------------------------------------------------------------------------
// tphc_cfg
// Configuration registers and the registered pseudo-header partial sum
// (addresses and protocol word).
// ----------------------------------------------------------------------------
module tphc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [tphc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tphc_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic [tphc_pkg::SumW-1:0]      cfg_sum_o
);
  import tphc_pkg::*;

  logic [AddrW-1:0]  src_addr_q, src_addr_d;
  logic [AddrW-1:0]  dst_addr_q, dst_addr_d;
  logic [ProtoW-1:0] proto_q, proto_d;
  logic [SumW-1:0]   cfg_sum_q, cfg_sum_d;

  logic [SumW+2:0]   total;
  logic [SumW:0]     fold1;

  always_comb begin
    src_addr_d = src_addr_q;
    dst_addr_d = dst_addr_q;
    proto_d    = proto_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SRC_ADDR: src_addr_d = cfg_data_i[AddrW-1:0];
        CFG_DST_ADDR: dst_addr_d = cfg_data_i[AddrW-1:0];
        CFG_PROTO:    proto_d    = cfg_data_i[ProtoW-1:0];
        default:      ;
      endcase
    end
  end

  // Five-word sum, then fold the carries back in twice
  always_comb begin
    total = {3'b000, src_addr_q[SumW-1:0]}
          + {3'b000, src_addr_q[AddrW-1:SumW]}
          + {3'b000, dst_addr_q[SumW-1:0]}
          + {3'b000, dst_addr_q[AddrW-1:SumW]}
          + {3'b000, proto_q, {ByteW{1'b0}}};
    fold1 = {1'b0, total[SumW-1:0]} + {{(SumW-2){1'b0}}, total[SumW+2:SumW]};
    cfg_sum_d = fold1[SumW-1:0] + {{(SumW-1){1'b0}}, fold1[SumW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_addr_q <= '0;
      dst_addr_q <= '0;
      proto_q    <= ProtoReset;
      cfg_sum_q  <= {ProtoReset, {ByteW{1'b0}}};
    end else begin
      src_addr_q <= src_addr_d;
      dst_addr_q <= dst_addr_d;
      proto_q    <= proto_d;
      cfg_sum_q  <= cfg_sum_d;
    end
  end

  assign cfg_sum_o = cfg_sum_q;

endmodule

// ===== design/tphc_front.sv =====
// ----------------------------------------------------------------------------
// tphc_front
// Byte intake: pair bytes into words, keep the running sum and byte count,
// and hand each finished segment to the queue.
// ----------------------------------------------------------------------------
module tphc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tphc_pkg::ByteW-1:0]   in_byte_i,
  input  logic                         in_last_i,
  input  tphc_pkg::fifo_stat_t         fifo_stat_i,
  output logic                         push_o,
  output tphc_pkg::seg_entry_t         push_data_o
);
  import tphc_pkg::*;

  logic [SumW-1:0]  sum_q, sum_d;
  logic [SumW-1:0]  count_q, count_d;
  logic             odd_q, odd_d;
  logic [ByteW-1:0] held_q;

  logic             accept;
  logic [SumW-1:0]  word;
  logic [SumW-1:0]  sum_new;
  logic [SumW-1:0]  count_new;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Complete a pair, or take a lone trailing byte as the low half
  assign word      = odd_q ? {in_byte_i, held_q} : {{ByteW{1'b0}}, in_byte_i};
  assign sum_new   = (odd_q || in_last_i) ? oc_add(sum_q, word) : sum_q;
  assign count_new = count_q + {{(SumW-1){1'b0}}, 1'b1};

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    odd_d   = odd_q;
    if (accept) begin
      if (in_last_i) begin
        sum_d   = '0;
        count_d = '0;
        odd_d   = 1'b0;
      end else begin
        sum_d   = sum_new;
        count_d = count_new;
        odd_d   = !odd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      odd_q   <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      odd_q   <= odd_d;
    end
  end

  // Held byte is only read while odd_q is set
  always_ff @(posedge clk_i) begin
    if (accept && !odd_q) begin
      held_q <= in_byte_i;
    end
  end

  assign push_o            = accept && in_last_i;
  assign push_data_o.sum   = sum_new;
  assign push_data_o.count = count_new;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (sum_q == '0) && (count_q == '0) && !odd_q)
    else $error("front state not cleared after last byte");

endmodule

// ===== design/tphc_fifo.sv =====
// ----------------------------------------------------------------------------
// tphc_fifo
// Short queue of finished segments between the byte front and the back end.
// ----------------------------------------------------------------------------
module tphc_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tphc_pkg::seg_entry_t   push_data_i,
  input  logic                   pop_i,
  output tphc_pkg::seg_entry_t   head_o,
  output tphc_pkg::fifo_stat_t   stat_o
);
  import tphc_pkg::*;

  seg_entry_t          mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;

  function automatic logic [FifoPtrW-1:0] ptr_inc(input logic [FifoPtrW-1:0] p);
    logic [FifoPtrW-1:0] nxt;
    if (p == FifoPtrW'(FifoDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = p + {{(FifoPtrW-1){1'b0}}, 1'b1};
    end
    return nxt;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + {{(FifoCntW-1){1'b0}}, 1'b1};
    end else if (pop_i && !push_i) begin
      count_d = count_q - {{(FifoCntW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == FifoCntW'(FifoDepth));
  assign stat_o.empty = (count_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("segment queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("segment queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("segment queue count beyond depth");

endmodule

// ===== design/tphc_back.sv =====
// ----------------------------------------------------------------------------
// tphc_back
// Finish a segment: add the byte count and pseudo-header words, invert,
// and hold the result in the output register.
// ----------------------------------------------------------------------------
module tphc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tphc_pkg::fifo_stat_t       fifo_stat_i,
  input  tphc_pkg::seg_entry_t       head_i,
  input  logic [tphc_pkg::SumW-1:0]  cfg_sum_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tphc_pkg::SumW-1:0]  out_data_o
);
  import tphc_pkg::*;

  logic            valid_q, valid_d;
  logic [SumW-1:0] data_q;

  logic [SumW-1:0] count_swapped;
  logic [SumW+1:0] total;
  logic [SumW:0]   fold1;
  logic [SumW-1:0] folded;

  // Take a new segment whenever the output register is free or draining
  assign pop_o = !fifo_stat_i.empty && (!valid_q || out_ready_i);

  // Count goes in big-endian: swap its bytes against the data word order
  assign count_swapped = {head_i.count[ByteW-1:0], head_i.count[SumW-1:ByteW]};

  always_comb begin
    total  = {2'b00, head_i.sum} + {2'b00, count_swapped} + {2'b00, cfg_sum_i};
    fold1  = {1'b0, total[SumW-1:0]} + {{(SumW-1){1'b0}}, total[SumW+1:SumW]};
    folded = fold1[SumW-1:0] + {{(SumW-1){1'b0}}, fold1[SumW]};
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= ~folded;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== design/transport_pseudo_header_checksum_unit.sv =====
// ----------------------------------------------------------------------------
// transport_pseudo_header_checksum_unit
// Ones'-complement transport checksum over a byte stream, with the IPv4
// pseudo-header (addresses, protocol, segment length) folded in.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  s_axis   | in        | tvalid / tready      | tdata[7:0] data_byte, tlast
//  m_axis   | out       | tvalid / tready      | tdata[15:0] checksum_value
//  cfg      | in        | cfg_valid / ready    | cfg_index, cfg_data (32 bit)
//
// One item (byte) is taken per cycle while the segment queue has room; the rate
// is set by the single 16-bit end-around-carry adder in the byte front.
// The checksum of a segment is registered first in the segment queue, then
// in the output register once that register is free or draining.
// A two-entry segment queue parts front and back, so input keeps flowing
// while a result waits on m_axis; input stalls only when the queue is full.
// Reset clears the sums, counters and queue at once (no clearing pass);
// the protocol register resets to 17, the addresses to zero.
// Configuration is always accepted; writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module transport_pseudo_header_checksum_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
  input  logic                           s_axis_tlast,   // is_last
  // stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,   // [15:0] checksum_value
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tphc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tphc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tphc_pkg::*;

  fifo_stat_t      fifo_stat;
  seg_entry_t      push_data;
  seg_entry_t      head;
  logic            push;
  logic            pop;
  logic [SumW-1:0] cfg_sum;

  // Writes never wait
  assign cfg_ready_o = 1'b1;

  // Hold addresses and protocol, and their pre-added pseudo-header sum
  tphc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_sum_o   (cfg_sum)
  );

  // Pair bytes, advance the running sum and count, push each finished segment
  tphc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tphc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  // Add length and pseudo-header, invert, hold until taken
  tphc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .head_i      (head),
    .cfg_sum_i   (cfg_sum),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
